// ===== src/smpq_pkg.sv =====
// Shared types and constants for the stable minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

	localparam int TAG_W = 16;
	localparam int PRIO_W = 32;
	localparam int DEF_QUEUE_DEPTH = 64;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_EXTRACT = 2'd1,
		KIND_PEEK    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PUT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic load_op;
		logic rd_en;
		logic rd_next;
		logic shift_wr;
		logic put_wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		kind_t in_kind;
		logic  empty;
		logic  full;
		logic  idx_one;
		logic  prio_le;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/smpq_datapath.sv =====
// Datapath: entry memory, count, operation registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module smpq_datapath #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEF_QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire smpq_pkg::cmd_t             cmd,
	output smpq_pkg::sts_t                  sts,
	input  wire logic [1:0]                 in_kind,
	input  wire logic [smpq_pkg::TAG_W-1:0] in_tag,
	input  wire logic [smpq_pkg::PRIO_W-1:0] in_prio,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [smpq_pkg::TAG_W-1:0]      out_tag,
	output logic [1:0]                      out_status,
	output logic [CW-1:0]                   out_fill,
	output logic                            out_empty
);
	import smpq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	entry_t          mem [QUEUE_DEPTH];
	entry_t          rd_q;
	entry_t          op_entry_q;
	kind_t           op_kind_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   rd_addr;
	logic [CW-1:0]   count_m1;
	status_t         fin_status;
	logic [TAG_W-1:0] fin_tag;
	logic [CW-1:0]   fin_count;

	assign count_m1 = count_q - CW'(1);
	assign rd_addr  = cmd.rd_next ? (idx_q - AW'(2)) : count_m1[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
		if (cmd.shift_wr)
			mem[idx_q] <= rd_q;
		else if (cmd.put_wr)
			mem[idx_q] <= op_entry_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_kind_q  <= kind_t'(in_kind);
			op_entry_q <= {in_prio, in_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_op) begin
			idx_q <= count_q[AW-1:0];
		end else if (cmd.shift_wr) begin
			idx_q <= idx_q - AW'(1);
		end
	end

	always_comb begin
		fin_status = ST_OK;
		fin_tag    = '0;
		fin_count  = count_q;
		case (op_kind_q)
			KIND_INSERT: begin
				if (sts.full)
					fin_status = ST_FULL;
				else
					fin_count = count_q + CW'(1);
			end
			KIND_EXTRACT: begin
				if (sts.empty) begin
					fin_status = ST_EMPTY;
				end else begin
					fin_tag   = rd_q.tag;
					fin_count = count_m1;
				end
			end
			KIND_PEEK: begin
				if (sts.empty)
					fin_status = ST_EMPTY;
				else
					fin_tag = rd_q.tag;
			end
			default: begin
				fin_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q   <= fin_count;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_tag    <= fin_tag;
			out_status <= fin_status;
			out_fill   <= fin_count;
			out_empty  <= (fin_count == '0);
		end
	end

	assign sts.in_kind  = kind_t'(in_kind);
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(QUEUE_DEPTH));
	assign sts.idx_one  = (idx_q == AW'(1));
	assign sts.prio_le  = (rd_q.prio <= op_entry_q.prio);
	assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== src/smpq_ctrl.sv =====
// Controller: state machine that sequences insert shifts, reads and results.
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire smpq_pkg::sts_t sts,
	output smpq_pkg::cmd_t      cmd
);
	import smpq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_op = 1'b1;
					case (sts.in_kind)
						KIND_INSERT: begin
							if (sts.full) begin
								state_d = S_FINISH;
							end else if (sts.empty) begin
								state_d = S_PUT;
							end else begin
								cmd.rd_en = 1'b1;
								state_d   = S_CMP;
							end
						end
						KIND_EXTRACT, KIND_PEEK: begin
							cmd.rd_en = !sts.empty;
							state_d   = S_FINISH;
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_CMP: begin
				if (sts.prio_le) begin
					cmd.shift_wr = 1'b1;
					if (sts.idx_one) begin
						state_d = S_PUT;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end else begin
					cmd.put_wr = 1'b1;
					state_d    = S_FINISH;
				end
			end
			S_PUT: begin
				cmd.put_wr = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/stable_min_priority_queue_core.sv =====
// Top level of the stable minimum priority queue.
//
//  channel   dir  tdata                                   tuser
//  s_*       in   elem_tag[15:0], prio_value[47:16]        kind
//  m_*       out  out_tag, fill_count, now_empty, zeros    status
//
// Extract, peek, no-op and full insert: from acceptance straight to S_FINISH.
// Insert: S_CMP shifts up each stored entry with priority <= the new one in turn,
// as the entry memory has a single read and write port; then the new entry is put.
// Reset clears count and control state only; entries are never read before written.
// A finished result waits in the output register while the next word is
// taken; a new result holds in the controller until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue_core #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEF_QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int OW = ((smpq_pkg::TAG_W + CW + 1 + 7) / 8) * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [47:0]   s_tdata,   // elem_tag, prio_value
	input  wire logic [1:0]    s_tuser,   // kind
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [OW-1:0]      m_tdata,   // out_tag, fill_count, now_empty, zero pad
	output logic [1:0]         m_tuser    // status
);
	import smpq_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [TAG_W-1:0] out_tag;
	logic [CW-1:0]    out_fill;
	logic             out_empty;

	smpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smpq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (s_tuser),
		.in_tag     (s_tdata[TAG_W-1:0]),
		.in_prio    (s_tdata[TAG_W +: PRIO_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_tag    (out_tag),
		.out_status (m_tuser),
		.out_fill   (out_fill),
		.out_empty  (out_empty)
	);

	assign m_tdata = OW'({out_empty, out_fill, out_tag});

endmodule

`default_nettype wire

// ===== src/smpq_checker.sv =====
// Port checker for the stable minimum priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smpq_checker #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEF_QUEUE_DEPTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int OW = ((smpq_pkg::TAG_W + CW + 1 + 7) / 8) * 8
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [OW-1:0] m_tdata,
	input wire logic [1:0]    m_tuser
);
	import smpq_pkg::*;

	logic [TAG_W-1:0] chk_tag;
	logic [CW-1:0]    chk_fill;
	logic             chk_empty;

	assign chk_tag   = m_tdata[TAG_W-1:0];
	assign chk_fill  = m_tdata[TAG_W +: CW];
	assign chk_empty = m_tdata[TAG_W + CW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_empty == (chk_fill == '0)))
		else $error("now_empty disagrees with fill_count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> chk_empty && (chk_tag == '0))
		else $error("empty status with entries or tag");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> (chk_fill == CW'(QUEUE_DEPTH)) && (chk_tag == '0))
		else $error("full status below depth");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_fill <= CW'(QUEUE_DEPTH)))
		else $error("fill_count beyond depth");

endmodule

bind stable_min_priority_queue_core smpq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_smpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
